/* hdl/pgxd_pkg.sv */
// Shared types and constants for the PGX byte-stream decoder.
// Used by pgxd_parser and pgx_stream_decoder; no dependencies.
`timescale 1ns / 1ps

package pgxd_pkg;

    // Largest accepted width or height
    localparam logic [16:0] MAX_DIM = 17'd16384;

    // Decimal accumulator saturates here
    localparam logic [16:0] ACC_MAX = 17'h1FFFF;

    // Signature bytes skipped at the start of each packet
    localparam logic [3:0] SIG_LEN = 4'd6;

    // Header characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_DEPTH     = 3'd2;
    localparam logic [2:0] ST_DIMS      = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;

    // Packet parse phase
    typedef enum logic [8:0] {
        PH_SIG    = 9'b000000001,
        PH_SIGN   = 9'b000000010,
        PH_SPACE  = 9'b000000100,
        PH_DEPTH  = 9'b000001000,
        PH_WIDTH  = 9'b000010000,
        PH_HEIGHT = 9'b000100000,
        PH_LF     = 9'b001000000,
        PH_PIX    = 9'b010000000,
        PH_DONE   = 9'b100000000
    } phase_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel_value;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [4:0]  bit_depth;
        logic        is_signed;
        logic        wide_samples;
        logic [2:0]  status;
        logic        last;
    } result_t;

endpackage

/* hdl/pgxd_parser.sv */
// Per-byte header parser and pixel formatter for the PGX decoder.
// Holds all packet state; depends on pgxd_pkg.
`timescale 1ns / 1ps

module pgxd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              res_valid,
    output pgxd_pkg::result_t res
);
    import pgxd_pkg::*;

    phase_t      phase_reg, phase_next, ph;
    logic [3:0]  hc_reg, hc_next;
    logic [16:0] acc_reg, acc_next;
    logic        seen_reg, seen_next;
    logic [4:0]  depth_reg, depth_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        sign_reg, sign_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [7:0]  hi_reg, hi_next;
    logic        half_reg, half_next;
    logic        failed_reg, failed_next;

    logic        used;
    logic        is_term;
    logic        is_digit;
    logic [20:0] acc_mul;
    logic [3:0]  hc_inc;
    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic        col_wrap;
    logic        row_end;
    logic [15:0] wide_val;
    logic [7:0]  narrow_val;
    logic [15:0] new_dim;
    logic        dims_bad;

    // Character classes and arithmetic helpers
    assign is_term  = (data_byte == CH_SPACE) || (data_byte == CH_LF) || (data_byte == CH_CR);
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign acc_mul  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {13'd0, data_byte - CH_ZERO};
    assign hc_inc   = hc_reg + 4'd1;
    assign col_inc  = {1'b0, col_reg} + 17'd1;
    assign row_inc  = {1'b0, row_reg} + 17'd1;
    assign col_wrap = col_inc >= {1'b0, width_reg};
    assign row_end  = row_inc >= {1'b0, height_reg};
    assign new_dim  = (acc_reg > 17'h0FFFF) ? 16'd0 : acc_reg[15:0];
    assign dims_bad = (width_reg == 16'd0) || (new_dim == 16'd0)
                    || ({1'b0, width_reg} > MAX_DIM) || ({1'b0, new_dim} > MAX_DIM);

    // Scale samples to full width
    always_comb
    begin
        wide_val   = {hi_reg, data_byte} << (5'd16 - depth_reg);
        narrow_val = data_byte << (5'd8 - depth_reg);
        if (sign_reg)
        begin
            wide_val   = wide_val ^ 16'h8000;
            narrow_val = narrow_val ^ 8'h80;
        end
    end

    // Work out next state and the result for one byte
    always_comb
    begin
        ph          = phase_reg;
        hc_next     = hc_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        depth_next  = depth_reg;
        width_next  = width_reg;
        height_next = height_reg;
        sign_next   = sign_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        hi_next     = hi_reg;
        half_next   = half_reg;
        failed_next = failed_reg;
        used        = 1'b0;
        res_valid   = 1'b0;
        res.kind    = KIND_PIXEL;
        res.pixel_value = 16'd0;
        res.status  = ST_OK;
        res.last    = 1'b0;

        if (!failed_reg && phase_reg != PH_DONE)
        begin
            // Skip signature
            if (ph == PH_SIG)
            begin
                hc_next = hc_inc;
                if (hc_inc >= SIG_LEN)
                    ph = PH_SIGN;
                used = 1'b1;
            end
            // Optional sign character
            if (!used && ph == PH_SIGN)
            begin
                if (data_byte == CH_PLUS)
                begin
                    sign_next = 1'b0;
                    used      = 1'b1;
                end
                else if (data_byte == CH_MINUS)
                begin
                    sign_next = 1'b1;
                    used      = 1'b1;
                end
                ph = PH_SPACE;
            end
            // Optional space
            if (!used && ph == PH_SPACE)
            begin
                if (data_byte == CH_SPACE)
                    used = 1'b1;
                ph = PH_DEPTH;
            end
            // Decimal fields
            if (!used && (ph == PH_DEPTH || ph == PH_WIDTH || ph == PH_HEIGHT))
            begin
                used = 1'b1;
                if (is_term)
                begin
                    if (!seen_reg)
                    begin
                        failed_next = 1'b1;
                        res_valid   = 1'b1;
                        res.kind    = KIND_ERROR;
                        res.status  = ST_MALFORMED;
                        res.last    = 1'b1;
                    end
                    else
                    begin
                        acc_next  = 17'd0;
                        seen_next = 1'b0;
                        if (ph == PH_DEPTH)
                        begin
                            depth_next = (acc_reg > 17'd31) ? 5'd0 : acc_reg[4:0];
                            ph = PH_WIDTH;
                        end
                        else if (ph == PH_WIDTH)
                        begin
                            width_next = new_dim;
                            ph = PH_HEIGHT;
                        end
                        else
                        begin
                            height_next = new_dim;
                            res_valid   = 1'b1;
                            if (dims_bad)
                            begin
                                failed_next = 1'b1;
                                res.kind    = KIND_ERROR;
                                res.status  = ST_DIMS;
                                res.last    = 1'b1;
                            end
                            else if (depth_reg == 5'd0 || depth_reg > 5'd16)
                            begin
                                failed_next = 1'b1;
                                res.kind    = KIND_ERROR;
                                res.status  = ST_DEPTH;
                                res.last    = 1'b1;
                            end
                            else
                            begin
                                ph       = PH_LF;
                                res.kind = KIND_HEADER;
                            end
                        end
                    end
                end
                else if (!is_digit)
                begin
                    failed_next = 1'b1;
                    res_valid   = 1'b1;
                    res.kind    = KIND_ERROR;
                    res.status  = ST_MALFORMED;
                    res.last    = 1'b1;
                end
                else
                begin
                    acc_next  = (acc_mul > {4'd0, ACC_MAX}) ? ACC_MAX : acc_mul[16:0];
                    seen_next = 1'b1;
                end
            end
            // Drop one LF after the header
            if (!used && ph == PH_LF)
            begin
                if (data_byte == CH_LF)
                    used = 1'b1;
                ph = PH_PIX;
            end
            // Pixel data
            if (!used && ph == PH_PIX)
            begin
                if (depth_reg > 5'd8 && !half_reg)
                begin
                    hi_next   = data_byte;
                    half_next = 1'b1;
                end
                else
                begin
                    half_next = 1'b0;
                    res_valid = 1'b1;
                    res.kind  = KIND_PIXEL;
                    res.pixel_value = (depth_reg > 5'd8) ? wide_val : {8'd0, narrow_val};
                    res.last  = col_wrap && row_end;
                    if (col_wrap)
                    begin
                        col_next = 16'd0;
                        row_next = row_inc[15:0];
                    end
                    else
                        col_next = col_inc[15:0];
                    if (col_wrap && row_end)
                        ph = PH_DONE;
                end
            end
            // Packet ended early
            if (last_byte && !failed_next && ph != PH_DONE)
            begin
                res_valid   = 1'b1;
                res.kind    = KIND_ERROR;
                res.pixel_value = 16'd0;
                res.status  = (ph == PH_LF || ph == PH_PIX) ? ST_SHORT : ST_MALFORMED;
                res.last    = 1'b1;
            end
        end

        // Report the fields as they stand after this byte
        res.image_width  = width_next;
        res.image_height = height_next;
        res.bit_depth    = depth_next;
        res.is_signed    = sign_next;
        res.wide_samples = depth_next > 5'd8;
        phase_next       = ph;

        // Clear packet state after the final byte
        if (last_byte)
        begin
            phase_next  = PH_SIG;
            hc_next     = 4'd0;
            acc_next    = 17'd0;
            seen_next   = 1'b0;
            depth_next  = 5'd0;
            width_next  = 16'd0;
            height_next = 16'd0;
            sign_next   = 1'b0;
            col_next    = 16'd0;
            row_next    = 16'd0;
            hi_next     = 8'd0;
            half_next   = 1'b0;
            failed_next = 1'b0;
        end
    end

    // Advance state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            hc_reg     <= 4'd0;
            acc_reg    <= 17'd0;
            seen_reg   <= 1'b0;
            depth_reg  <= 5'd0;
            width_reg  <= 16'd0;
            height_reg <= 16'd0;
            sign_reg   <= 1'b0;
            col_reg    <= 16'd0;
            row_reg    <= 16'd0;
            hi_reg     <= 8'd0;
            half_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            depth_reg  <= depth_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            sign_reg   <= sign_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            hi_reg     <= hi_next;
            half_reg   <= half_next;
            failed_reg <= failed_next;
        end
    end

endmodule

/* hdl/pgx_stream_decoder.sv */
// Top level of the PGX byte-stream decoder: input handshake and result register.
// Depends on pgxd_pkg and pgxd_parser.
`timescale 1ns / 1ps

// Usage:
//   Packet bytes enter on the s_ group, one byte per transfer, with s_tlast on
//   the final byte of a packet. Results leave on the m_ group: m_tuser gives
//   the kind (pixel, header, error), m_tdata the payload, m_tlast marks the
//   final pixel of an image or any error report.
//   A byte produces zero or one result. The result is held in the output
//   register and shows on m_ the cycle after its byte is transferred.
//   Throughput is one byte per cycle: the parser updates its state and builds
//   the result in a single pass between the input handshake and the output
//   register.
//   When the receiver stalls, the result register holds its transfer and
//   s_tready drops until the register empties; a byte is still taken in the
//   cycle the held result leaves.
//   Reset returns the parser to the signature skip and empties the output
//   register. Packet state also returns to that point after every s_tlast byte.
module pgx_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] pixel_value, [31:16] image_width,
                                   // [47:32] image_height, [52:48] bit_depth,
                                   // [53] is_signed, [54] wide_samples,
                                   // [57:55] status, [63:58] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);
    import pgxd_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    pgxd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= accept && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.wide_samples, out_reg.is_signed,
                       out_reg.bit_depth, out_reg.image_height, out_reg.image_width,
                       out_reg.pixel_value};

endmodule

/* sim/pgx_stream_decoder_test.sv */
// Self-checking testbench for pgx_stream_decoder: directed packets, then random PGX packets.
// Depends on pgxd_pkg and the decoder RTL; holds its own byte-level decoder model.
`timescale 1ns / 1ps

module pgx_stream_decoder_test;

    import pgxd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 550;
    localparam int CALM_ITEMS     = 80;
    localparam int DIRECTED_COUNT = 26;

    // How a directed row is checked
    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_QUIET   = 2'd1;
    localparam logic [1:0] ROW_TYPED   = 2'd2;

    // Error report with every header register still clear
    localparam result_t MALFORMED_CLEAR =
        {KIND_ERROR, 16'd0, 16'd0, 16'd0, 5'd0, 1'b0, 1'b0, ST_MALFORMED, 1'b1};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] mode;
        result_t    typed;
    } stim_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    pgx_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Decoder model state
    phase_t      ph;
    logic [3:0]  hdr_cnt;
    logic [16:0] acc;
    logic        got_digit;
    logic [4:0]  hdr_depth;
    logic [15:0] hdr_width;
    logic [15:0] hdr_height;
    logic        sgn;
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  hi_byte;
    logic        half;
    logic        failed_q;

    result_t     pending_results[$];
    logic [7:0]  pkt[$];
    stim_row_t   directed_rows [DIRECTED_COUNT];

    bit          idle_on = 1'b0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          bytes_parsed = 0;
    int          results_checked = 0;
    int          headers_seen = 0;
    int          pixels_seen = 0;
    int          errors_seen = 0;
    int          cycles = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stall bursts while idling is enabled
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic result_t result_from_state(logic [1:0] k, logic [15:0] pix,
                                                  logic [2:0] st, logic l);
        result_t r;
        r.kind         = k;
        r.pixel_value  = pix;
        r.image_width  = hdr_width;
        r.image_height = hdr_height;
        r.bit_depth    = hdr_depth;
        r.is_signed    = sgn;
        r.wide_samples = hdr_depth > 5'd8;
        r.status       = st;
        r.last         = l;
        return r;
    endfunction

    task automatic clear_decoder_state();
        ph         = PH_SIG;
        hdr_cnt    = 4'd0;
        acc        = 17'd0;
        got_digit  = 1'b0;
        hdr_depth  = 5'd0;
        hdr_width  = 16'd0;
        hdr_height = 16'd0;
        sgn        = 1'b0;
        col        = 16'd0;
        row        = 16'd0;
        hi_byte    = 8'd0;
        half       = 1'b0;
        failed_q   = 1'b0;
    endtask

    // Step the raster position and build the pixel result
    task automatic advance_pixel(input logic [15:0] val, output result_t res);
        logic col_end;
        logic fin;
        col_end = ({1'b0, col} + 17'd1) >= {1'b0, hdr_width};
        fin     = col_end && (({1'b0, row} + 17'd1) >= {1'b0, hdr_height});
        if (col_end)
        begin
            col = 16'd0;
            row = row + 16'd1;
        end
        else
            col = col + 16'd1;
        if (fin)
            ph = PH_DONE;
        res = result_from_state(KIND_PIXEL, val, ST_OK, fin);
    endtask

    // Decode one transferred byte; busy is low when the byte is ignored
    task automatic decode_byte(input logic [7:0] b, input logic lastb,
                               output logic produced, output logic busy,
                               output result_t res);
        logic        used;
        logic [16:0] num;
        int unsigned acc_next;
        logic [31:0] scaled;
        produced = 1'b0;
        res      = '0;
        used     = 1'b0;
        busy     = !(failed_q || ph == PH_DONE);
        if (busy)
        begin
            // Signature skip
            if (ph == PH_SIG)
            begin
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt >= SIG_LEN)
                    ph = PH_SIGN;
                used = 1'b1;
            end
            // Optional sign, then optional space
            if (!used && ph == PH_SIGN)
            begin
                if (b == CH_PLUS)
                begin
                    sgn  = 1'b0;
                    used = 1'b1;
                end
                else if (b == CH_MINUS)
                begin
                    sgn  = 1'b1;
                    used = 1'b1;
                end
                ph = PH_SPACE;
            end
            if (!used && ph == PH_SPACE)
            begin
                if (b == CH_SPACE)
                    used = 1'b1;
                ph = PH_DEPTH;
            end
            // Decimal depth, width and height
            if (!used && ph inside {PH_DEPTH, PH_WIDTH, PH_HEIGHT})
            begin
                used = 1'b1;
                if (b == CH_SPACE || b == CH_LF || b == CH_CR)
                begin
                    if (!got_digit)
                    begin
                        failed_q = 1'b1;
                        res      = result_from_state(KIND_ERROR, 16'd0, ST_MALFORMED, 1'b1);
                        produced = 1'b1;
                    end
                    else
                    begin
                        num       = acc;
                        acc       = 17'd0;
                        got_digit = 1'b0;
                        if (ph == PH_DEPTH)
                        begin
                            hdr_depth = (num > 17'd31) ? 5'd0 : num[4:0];
                            ph        = PH_WIDTH;
                        end
                        else if (ph == PH_WIDTH)
                        begin
                            hdr_width = (num > 17'hFFFF) ? 16'd0 : num[15:0];
                            ph        = PH_HEIGHT;
                        end
                        else
                        begin
                            hdr_height = (num > 17'hFFFF) ? 16'd0 : num[15:0];
                            produced   = 1'b1;
                            if (hdr_width == 16'd0 || hdr_height == 16'd0 ||
                                hdr_width > MAX_DIM || hdr_height > MAX_DIM)
                            begin
                                failed_q = 1'b1;
                                res = result_from_state(KIND_ERROR, 16'd0, ST_DIMS, 1'b1);
                            end
                            else if (hdr_depth == 5'd0 || hdr_depth > 5'd16)
                            begin
                                failed_q = 1'b1;
                                res = result_from_state(KIND_ERROR, 16'd0, ST_DEPTH, 1'b1);
                            end
                            else
                            begin
                                ph  = PH_LF;
                                res = result_from_state(KIND_HEADER, 16'd0, ST_OK, 1'b0);
                            end
                        end
                    end
                end
                else if (b < CH_ZERO || b > CH_NINE)
                begin
                    failed_q = 1'b1;
                    res      = result_from_state(KIND_ERROR, 16'd0, ST_MALFORMED, 1'b1);
                    produced = 1'b1;
                end
                else
                begin
                    acc_next  = int'(acc) * 10 + int'(b - CH_ZERO);
                    acc       = (acc_next > ACC_MAX) ? ACC_MAX : acc_next[16:0];
                    got_digit = 1'b1;
                end
            end
            // Drop one LF after the header
            if (!used && ph == PH_LF)
            begin
                if (b == CH_LF)
                    used = 1'b1;
                ph = PH_PIX;
            end
            // Pixel data: big-endian pairs above 8 bits
            if (!used && ph == PH_PIX)
            begin
                if (hdr_depth > 5'd8)
                begin
                    if (!half)
                    begin
                        hi_byte = b;
                        half    = 1'b1;
                    end
                    else
                    begin
                        half   = 1'b0;
                        scaled = {16'd0, hi_byte, b} << (5'd16 - hdr_depth);
                        if (sgn)
                            scaled = scaled ^ 32'h8000;
                        advance_pixel(scaled[15:0], res);
                        produced = 1'b1;
                    end
                end
                else
                begin
                    scaled = {24'd0, b} << (5'd8 - hdr_depth);
                    if (sgn)
                        scaled = scaled ^ 32'h80;
                    advance_pixel({8'd0, scaled[7:0]}, res);
                    produced = 1'b1;
                end
            end
            // Packet ended before the image was complete
            if (lastb && !failed_q && ph != PH_DONE)
            begin
                res = result_from_state(KIND_ERROR, 16'd0,
                          (ph inside {PH_LF, PH_PIX}) ? ST_SHORT : ST_MALFORMED, 1'b1);
                produced = 1'b1;
            end
        end
        if (lastb)
            clear_decoder_state();
    endtask

    // Hold the byte on the slave side until it is transferred
    task automatic transfer_byte(input logic [7:0] b, input logic l);
        logic hs;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do
        begin
            @(negedge clk);
            hs = s_tready;
            @(posedge clk);
        end
        while (!hs);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            mismatches = mismatches + 1;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Check every result transfer against the oldest expectation
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected result, expected none, actual kind %h data %h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked = results_checked + 1;
                case (want.kind)
                    KIND_HEADER: headers_seen = headers_seen + 1;
                    KIND_ERROR:  errors_seen  = errors_seen + 1;
                    default:     pixels_seen  = pixels_seen + 1;
                endcase
                compare_field("kind",   16'(want.kind),         16'(m_tuser));
                compare_field("pixel",  want.pixel_value,       m_tdata[15:0]);
                compare_field("width",  want.image_width,       m_tdata[31:16]);
                compare_field("height", want.image_height,      m_tdata[47:32]);
                compare_field("depth",  16'(want.bit_depth),    16'(m_tdata[52:48]));
                compare_field("signed", 16'(want.is_signed),    16'(m_tdata[53]));
                compare_field("wide",   16'(want.wide_samples), 16'(m_tdata[54]));
                compare_field("status", 16'(want.status),       16'(m_tdata[57:55]));
                compare_field("pad",    16'd0,                  16'(m_tdata[63:58]));
                compare_field("last",   16'(want.last),         16'(m_tlast));
            end
        end
    end

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned pick_depth();
        if ($urandom_range(0, 6) != 0)
            return $urandom_range(1, 16);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 17;
            2:       return 31;
            3:       return 32;
            default: return 999999;
        endcase
    endfunction

    function automatic int unsigned pick_dim();
        if ($urandom_range(0, 6) != 0)
            return $urandom_range(1, 4);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 16384;
            2:       return 16385;
            3:       return 65535;
            4:       return 65536;
            default: return 200000;
        endcase
    endfunction

    // Append a decimal number, now and then with a leading zero or no digits
    task automatic push_number(input int unsigned v);
        string digits;
        if ($urandom_range(0, 29) == 0)
            return;
        if ($urandom_range(0, 9) == 0)
            pkt.push_back(CH_ZERO);
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++)
            pkt.push_back(digits[i]);
    endtask

    task automatic push_number_end();
        case ($urandom_range(0, 2))
            0:       pkt.push_back(CH_SPACE);
            1:       pkt.push_back(CH_LF);
            default: pkt.push_back(CH_CR);
        endcase
    endtask

    // Build one packet: mostly well formed, some cut, padded, corrupted or noise
    task automatic build_packet();
        int unsigned dv;
        int unsigned wv;
        int unsigned hv;
        int unsigned npix;
        int unsigned cut;
        pkt.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 16)) pkt.push_back(random_byte());
            return;
        end
        repeat (SIG_LEN) pkt.push_back(random_byte());
        case ($urandom_range(0, 2))
            1:       pkt.push_back(CH_PLUS);
            2:       pkt.push_back(CH_MINUS);
            default: ;
        endcase
        if ($urandom_range(0, 1))
            pkt.push_back(CH_SPACE);
        dv = pick_depth();
        wv = pick_dim();
        hv = pick_dim();
        push_number(dv);
        push_number_end();
        push_number(wv);
        push_number_end();
        push_number(hv);
        push_number_end();
        if ($urandom_range(0, 1))
            pkt.push_back(CH_LF);
        // Large images are always sent short
        npix = (wv <= 4 && hv <= 4) ? wv * hv : $urandom_range(0, 3);
        repeat (npix * ((dv > 8) ? 2 : 1)) pkt.push_back(random_byte());
        if ($urandom_range(0, 7) == 0 && pkt.size() > 1)
        begin
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
        else if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) pkt.push_back(random_byte());
        if ($urandom_range(0, 9) == 0)
            pkt[$urandom_range(0, pkt.size() - 1)] = random_byte();
    endtask

    // Stimulus and end of run
    initial
    begin
        logic    produced;
        logic    busy;
        result_t res;

        directed_rows = '{
            // Packet ends on its first signature byte
            stim_row_t'{8'h00, 1'b1, ROW_TYPED, MALFORMED_CLEAR},
            // Signed 16-bit 1x1 image, CR and LF terminators, LF dropped
            stim_row_t'{8'hFF, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'h00, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'hFF, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'h00, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'hA5, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'h5A, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{CH_MINUS, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{CH_SPACE, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{8'h31, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{8'h36, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{CH_SPACE, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{8'h31, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{CH_CR, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{8'h31, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{CH_LF, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{CH_LF, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{8'hFF, 1'b0, ROW_PREDICT, result_t'('0)},
            stim_row_t'{8'hFF, 1'b1, ROW_PREDICT, result_t'('0)},
            // Non-digit where the depth should start
            stim_row_t'{8'h00, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'hFF, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'h00, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'hFF, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'h00, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'hFF, 1'b0, ROW_QUIET, result_t'('0)},
            stim_row_t'{8'h78, 1'b1, ROW_TYPED, MALFORMED_CLEAR}
        };

        clear_decoder_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            transfer_byte(directed_rows[i].data, directed_rows[i].last);
            decode_byte(directed_rows[i].data, directed_rows[i].last, produced, busy, res);
            if (directed_rows[i].mode == ROW_TYPED)
                pending_results.push_back(directed_rows[i].typed);
            else if (directed_rows[i].mode == ROW_PREDICT && produced)
                pending_results.push_back(res);
        end

        // Random packets; the final stretch runs without idling
        while (bytes_parsed < RANDOM_ITEMS)
        begin
            idle_on = (bytes_parsed < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 4) != 0);
            build_packet();
            for (int i = 0; i < pkt.size(); i++)
            begin
                transfer_byte(pkt[i], i == pkt.size() - 1);
                decode_byte(pkt[i], i == pkt.size() - 1, produced, busy, res);
                if (produced)
                    pending_results.push_back(res);
                if (busy)
                    bytes_parsed = bytes_parsed + 1;
            end
        end
        s_tvalid <= 1'b0;

        // Drain the result register
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d bytes, %0d of them parsed in the random packets",
                 bytes_sent, bytes_parsed);
        $display("Checked %0d results: %0d headers, %0d pixels, %0d error reports",
                 results_checked, headers_seen, pixels_seen, errors_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
